// ===== rtl/chsf_pkg.sv =====
`default_nettype none
package chsf_pkg;

  localparam int SEP_W   = 32;
  localparam int MAG_W   = 32;
  localparam int CFG_W   = 31;
  localparam int DIM_W   = 2;
  localparam int SUMSQ_W = 64;
  localparam int ROOT_W  = 32;
  localparam int NUM_W   = 64;
  localparam int DEN_W   = 33;
  localparam int QUO_W   = 32;
  localparam int LANES   = 3;

  localparam logic [1:0] REG_SPRING_CONSTANT = 2'd0;
  localparam logic [1:0] REG_REST_LENGTH     = 2'd1;
  localparam logic [1:0] REG_FORCE_CAP       = 2'd2;
  localparam logic [1:0] REG_DIMENSIONS      = 2'd3;

  localparam logic [DIM_W-1:0] DIM_2D = 2'd2;

  typedef struct packed {
    logic                    first_head_bound;
    logic                    second_head_bound;
    logic signed [SEP_W-1:0] sep_x;
    logic signed [SEP_W-1:0] sep_y;
    logic signed [SEP_W-1:0] sep_z;
  } chsf_in_t;

  typedef struct packed {
    logic signed [SEP_W-1:0] force_x;
    logic signed [SEP_W-1:0] force_y;
    logic signed [SEP_W-1:0] force_z;
    logic [SEP_W-1:0]        energy;
  } chsf_out_t;

endpackage
`default_nettype wire

// ===== rtl/capped_harmonic_spring_force.sv =====
`default_nettype none
// the result is strobed on done once the item has passed the whole pipeline
// throughput: one word per cycle, set by the fully pipelined square root
// and the two 32-step pipelined dividers; busy stays low
// the receiver cannot stall, results show for one cycle only
// reset: synchronous, clears the pipeline valid bits and loads register defaults
module capped_harmonic_spring_force import chsf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  chsf_in_t         item,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_addr,
  input  logic [CFG_W-1:0] cfg_data,
  output logic             done,
  output chsf_out_t        result
);

  localparam int RootStage  = 2 + ROOT_W;
  localparam int QuoStage   = RootStage + QUO_W;
  localparam int ForceStage = QuoStage + 3;
  localparam int EsumStage  = ForceStage + 2;
  localparam int EnStage    = EsumStage + QUO_W;
  localparam int OutStage   = EnStage + 1;
  localparam int ForceDly   = EnStage - ForceStage;

  typedef struct packed {
    logic [LANES-1:0][MAG_W-1:0] dmag;
    logic [LANES-1:0]            dneg;
    logic                        ok;
    logic                        zero;
  } side_a_t;

  typedef struct packed {
    logic [LANES-1:0][MAG_W-1:0] dmag;
    logic [LANES-1:0]            dneg;
    logic                        kill;
    logic                        big;
  } side_b_t;

  typedef struct packed {
    logic ezero;
    logic esat;
  } eflag_t;

  logic [CFG_W-1:0] spring_constant;
  logic [CFG_W-1:0] rest_length;
  logic [CFG_W-1:0] force_cap;
  logic [DIM_W-1:0] dimensions;

  logic [OutStage:0] vld;

  logic [LANES-1:0][MAG_W-1:0] in_mag;
  logic [LANES-1:0]            in_neg;
  logic [LANES-1:0][MAG_W-1:0] dmag0, dmag1, dmag2;
  logic [LANES-1:0]            dneg0, dneg1, dneg2;
  logic                        ok0, ok1, ok2;
  logic [SUMSQ_W-1:0]          sq1 [LANES];
  logic [2*CFG_W-1:0]          kr;
  logic [SUMSQ_W-1:0]          ssum;

  side_a_t sa [ROOT_W];
  side_b_t sb [QUO_W];

  logic [ROOT_W-1:0] root;
  logic              kill;
  logic              big;
  logic [QUO_W-1:0]  q;

  logic signed [CFG_W+2:0] f_raw;
  logic [CFG_W+2:0]        f_abs;
  logic [CFG_W-1:0]        f_mag_next;
  logic                    f_neg_next;
  logic [CFG_W-1:0]        f_mag;
  logic                    f_neg;
  logic [LANES-1:0][MAG_W-1:0] fdmag;
  logic [LANES-1:0]            fdneg;

  logic signed [SEP_W-1:0] lane_force [LANES];
  logic [SUMSQ_W-1:0]      lane_sq    [LANES];
  logic [LANES-1:0][SEP_W-1:0] fd [ForceDly];

  logic [SUMSQ_W-1:0] esum;
  logic [QUO_W-1:0]   equo;
  eflag_t             ef [QUO_W];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      spring_constant <= CFG_W'(65536);
      rest_length     <= '0;
      force_cap       <= '1;
      dimensions      <= DIM_W'(3);
      vld             <= '0;
    end else begin
      vld <= {vld[OutStage-1:0], start};
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_SPRING_CONSTANT: spring_constant <= cfg_data;
          REG_REST_LENGTH:     rest_length     <= cfg_data;
          REG_FORCE_CAP:       force_cap       <= cfg_data;
          REG_DIMENSIONS:      dimensions      <= cfg_data[DIM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    in_neg[0] = item.sep_x[SEP_W-1];
    in_neg[1] = item.sep_y[SEP_W-1];
    in_neg[2] = item.sep_z[SEP_W-1];
    in_mag[0] = in_neg[0] ? MAG_W'(-item.sep_x) : MAG_W'(item.sep_x);
    in_mag[1] = in_neg[1] ? MAG_W'(-item.sep_y) : MAG_W'(item.sep_y);
    in_mag[2] = in_neg[2] ? MAG_W'(-item.sep_z) : MAG_W'(item.sep_z);
    if (dimensions == DIM_2D) begin
      in_mag[2] = '0;
    end
  end

  always_ff @(posedge clk) begin
    dmag0 <= in_mag;
    dneg0 <= in_neg;
    ok0   <= item.first_head_bound & item.second_head_bound;
    for (int i = 0; i < LANES; i++) begin
      sq1[i] <= dmag0[i] * dmag0[i];
    end
    kr    <= spring_constant * rest_length;
    dmag1 <= dmag0;
    dneg1 <= dneg0;
    ok1   <= ok0;
    ssum  <= sq1[0] + sq1[1] + sq1[2];
    dmag2 <= dmag1;
    dneg2 <= dneg1;
    ok2   <= ok1;
  end

  chsf_isqrt u_isqrt (
    .clk      (clk),
    .radicand (ssum),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    sa[0] <= '{dmag: dmag2, dneg: dneg2, ok: ok2, zero: (ssum == '0)};
    for (int i = 1; i < ROOT_W; i++) begin
      sa[i] <= sa[i-1];
    end
  end

  assign kill = !sa[ROOT_W-1].ok || ((rest_length != '0) && sa[ROOT_W-1].zero);
  assign big  = ROOT_W'(kr[2*CFG_W-1:QUO_W]) >= root;

  chsf_div u_div_len (
    .clk (clk),
    .num (NUM_W'(kr)),
    .den (DEN_W'(root)),
    .quo (q)
  );

  always_ff @(posedge clk) begin
    sb[0] <= '{dmag: sa[ROOT_W-1].dmag, dneg: sa[ROOT_W-1].dneg, kill: kill, big: big};
    for (int i = 1; i < QUO_W; i++) begin
      sb[i] <= sb[i-1];
    end
  end

  always_comb begin
    if (rest_length == '0) begin
      f_raw = $signed((CFG_W+3)'(spring_constant));
    end else begin
      f_raw = $signed((CFG_W+3)'(spring_constant)) - $signed((CFG_W+3)'(q));
    end
    f_neg_next = f_raw[CFG_W+2];
    f_abs      = f_neg_next ? (CFG_W+3)'(-f_raw) : (CFG_W+3)'(f_raw);
    f_mag_next = f_abs[CFG_W-1:0];
    if ((rest_length != '0) && sb[QUO_W-1].big) begin
      f_neg_next = 1'b1;
      f_mag_next = force_cap;
    end else if (f_abs > (CFG_W+3)'(force_cap)) begin
      f_mag_next = force_cap;
    end
    if (sb[QUO_W-1].kill) begin
      f_neg_next = 1'b0;
      f_mag_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    f_mag <= f_mag_next;
    f_neg <= f_neg_next;
    fdmag <= sb[QUO_W-1].dmag;
    fdneg <= sb[QUO_W-1].dneg;
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    chsf_lane u_lane (
      .clk       (clk),
      .d_mag     (fdmag[l]),
      .d_neg     (fdneg[l]),
      .f_mag     (f_mag),
      .f_neg     (f_neg),
      .force_val (lane_force[l]),
      .force_sq  (lane_sq[l])
    );
  end

  always_ff @(posedge clk) begin
    esum  <= lane_sq[0] + lane_sq[1] + lane_sq[2];
    fd[0] <= {lane_force[0], lane_force[1], lane_force[2]};
    for (int i = 1; i < ForceDly; i++) begin
      fd[i] <= fd[i-1];
    end
  end

  chsf_div u_div_energy (
    .clk (clk),
    .num (esum),
    .den ({spring_constant, 2'b00}),
    .quo (equo)
  );

  always_ff @(posedge clk) begin
    ef[0] <= '{ezero: (esum == '0),
               esat:  ({1'b0, esum[SUMSQ_W-1:QUO_W]} >= {spring_constant, 2'b00})};
    for (int i = 1; i < QUO_W; i++) begin
      ef[i] <= ef[i-1];
    end
  end

  always_ff @(posedge clk) begin
    result.force_x <= fd[ForceDly-1][2];
    result.force_y <= fd[ForceDly-1][1];
    result.force_z <= fd[ForceDly-1][0];
    if (ef[QUO_W-1].ezero) begin
      result.energy <= '0;
    end else if (ef[QUO_W-1].esat) begin
      result.energy <= '1;
    end else begin
      result.energy <= equo;
    end
  end

  assign done = vld[OutStage];

endmodule
`default_nettype wire

// ===== rtl/chsf_isqrt.sv =====
`default_nettype none
module chsf_isqrt import chsf_pkg::*; (
  input  logic               clk,
  input  logic [SUMSQ_W-1:0] radicand,
  output logic [ROOT_W-1:0]  root
);

  localparam int RemW = ROOT_W + 2;

  logic [SUMSQ_W-1:0] rad_q  [ROOT_W];
  logic [RemW-1:0]    rem_q  [ROOT_W];
  logic [ROOT_W-1:0]  root_q [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_step
    logic [SUMSQ_W-1:0] rad_in;
    logic [RemW-1:0]    rem_in;
    logic [ROOT_W-1:0]  root_in;
    logic [RemW+1:0]    acc;
    logic [RemW+1:0]    trial;

    if (i == 0) begin : g_first
      assign rad_in  = radicand;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
    end

    assign acc   = {rem_in, rad_in[SUMSQ_W-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk) begin
      rad_q[i] <= rad_in << 2;
      if (acc >= trial) begin
        rem_q[i]  <= RemW'(acc - trial);
        root_q[i] <= {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q[i]  <= RemW'(acc);
        root_q[i] <= {root_in[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign root = root_q[ROOT_W-1];

endmodule
`default_nettype wire

// ===== rtl/chsf_div.sv =====
`default_nettype none
module chsf_div import chsf_pkg::*; (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  // quotient must fit QUO_W bits: upper half of num below den
  logic [QUO_W-1:0] lo_q  [QUO_W];
  logic [DEN_W-1:0] rem_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];

  for (genvar i = 0; i < QUO_W; i++) begin : g_step
    logic [QUO_W-1:0] lo_in;
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    logic [DEN_W:0]   acc;

    if (i == 0) begin : g_first
      assign lo_in  = num[QUO_W-1:0];
      assign rem_in = DEN_W'(num[NUM_W-1:QUO_W]);
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign lo_in  = lo_q[i-1];
      assign rem_in = rem_q[i-1];
      assign den_in = den_q[i-1];
      assign quo_in = quo_q[i-1];
    end

    assign acc = {rem_in, lo_in[QUO_W-1]};

    always_ff @(posedge clk) begin
      lo_q[i]  <= lo_in << 1;
      den_q[i] <= den_in;
      if (acc >= {1'b0, den_in}) begin
        rem_q[i] <= DEN_W'(acc - {1'b0, den_in});
        quo_q[i] <= {quo_in[QUO_W-2:0], 1'b1};
      end else begin
        rem_q[i] <= DEN_W'(acc);
        quo_q[i] <= {quo_in[QUO_W-2:0], 1'b0};
      end
    end
  end

  assign quo = quo_q[QUO_W-1];

endmodule
`default_nettype wire

// ===== rtl/chsf_lane.sv =====
`default_nettype none
module chsf_lane import chsf_pkg::*; (
  input  logic                    clk,
  input  logic [MAG_W-1:0]        d_mag,
  input  logic                    d_neg,
  input  logic [CFG_W-1:0]        f_mag,
  input  logic                    f_neg,
  output logic signed [SEP_W-1:0] force_val,
  output logic [SUMSQ_W-1:0]      force_sq
);

  localparam int ProdW = MAG_W + CFG_W;
  localparam logic [ProdW-17:0] NegLim = (ProdW-16)'(64'h8000_0000);
  localparam logic [ProdW-17:0] PosLim = (ProdW-16)'(64'h7FFF_FFFF);

  logic [ProdW-1:0]    prod;
  logic                neg;
  logic [ProdW-17:0]   m;
  logic [MAG_W-1:0]    mag_sat;
  logic                neg_out;
  logic [MAG_W-1:0]    fmag;

  always_ff @(posedge clk) begin
    prod <= d_mag * f_mag;
    neg  <= d_neg ^ f_neg;
  end

  assign m = prod[ProdW-1:16];

  always_comb begin
    neg_out = neg && (m != '0);
    if (neg_out) begin
      mag_sat = (m > NegLim) ? MAG_W'(NegLim) : m[MAG_W-1:0];
    end else begin
      mag_sat = (m > PosLim) ? MAG_W'(PosLim) : m[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    fmag      <= mag_sat;
    force_val <= neg_out ? -$signed(mag_sat) : $signed(mag_sat);
    force_sq  <= fmag * fmag;
  end

endmodule
`default_nettype wire
